[src/pbrle_pkg.sv]
// shared types and constants for the packbits run-length encoder
// no dependencies; imported by every module of the block except pbrle_ram
`default_nettype none

package pbrle_pkg;

  localparam int CHUNK_LIMIT = 128;
  localparam int FILL_W      = $clog2(CHUNK_LIMIT + 1);
  localparam int ADDR_W      = $clog2(CHUNK_LIMIT);
  localparam int RUN_W       = $clog2(CHUNK_LIMIT + 1);

  localparam logic [7:0] END_MARK = 8'd128;
  localparam logic [8:0] RUN_BASE = 9'd257;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte_0;
    logic [7:0] out_byte_1;
    logic [7:0] out_byte_2;
    logic [7:0] out_byte_3;
    logic [2:0] valid_bytes;
    logic       last_word;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RUN_HDR,
    ST_RUN_VAL,
    ST_FLUSH_HDR,
    ST_FLUSH_DATA,
    ST_FIN,
    ST_FIN_FLUSH,
    ST_END_MARK,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    EM_RUN_HDR,
    EM_RUN_VAL,
    EM_LIT_HDR,
    EM_LIT_DATA,
    EM_END
  } emit_sel_t;

  // controller to datapath
  typedef struct packed {
    logic      accept;
    logic      pend_load_new;
    logic      pend_inc;
    logic      pend_cont;
    logic      pend_clear;
    logic      run_load_pend;
    logic      run_load_full;
    logic      lit_append;
    logic      fill_clear;
    logic      idx_inc;
    logic      emit;
    emit_sel_t emit_sel;
    logic      step_end;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pc_zero;
    logic pc_one;
    logic pc_full;
    logic byte_match;
    logic run_cont;
    logic fill_zero;
    logic fill_almost;
    logic idx_last;
    logic fin_in;
    logic fin_r;
  } status_t;

endpackage

`default_nettype wire

[src/pbrle_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module pbrle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/pbrle_packer.sv]
// gathers encoded bytes into words of four and holds the result register
// depends on pbrle_pkg
`default_nettype none

module pbrle_packer
  import pbrle_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       emit,
  input  wire logic [7:0] emit_byte,
  input  wire logic       step_end,
  output logic            ready,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_item
);

  logic [7:0] acc_r [4];
  logic [7:0] acc_nxt [4];
  logic [2:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_item_r, out_item_nxt;
  logic [7:0] word_b [4];

  assign ready     = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // bytes past the count read as zero
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      word_b[j] = (3'(j) < cnt_r) ? acc_r[j] : 8'd0;
    end
  end

  always_comb begin
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    if (emit) begin
      if (cnt_r == 3'd4) begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{out_byte_0: word_b[0], out_byte_1: word_b[1],
                          out_byte_2: word_b[2], out_byte_3: word_b[3],
                          valid_bytes: cnt_r, last_word: 1'b0};
        acc_nxt[0] = emit_byte;
        cnt_nxt    = 3'd1;
      end else begin
        acc_nxt[cnt_r[1:0]] = emit_byte;
        cnt_nxt             = cnt_r + 3'd1;
      end
    end else if (step_end && cnt_r != 3'd0) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = '{out_byte_0: word_b[0], out_byte_1: word_b[1],
                        out_byte_2: word_b[2], out_byte_3: word_b[3],
                        valid_bytes: cnt_r, last_word: 1'b1};
      cnt_nxt = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    acc_r      <= acc_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

`default_nettype wire

[src/pbrle_datapath.sv]
// encoder datapath: open group, run and literal registers, literal store, byte select
// depends on pbrle_pkg and pbrle_ram
`default_nettype none

module pbrle_datapath
  import pbrle_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire in_item_t   in_item,
  input  wire cmd_t       cmd,
  output status_t         status,
  output logic [7:0]      emit_byte
);

  logic [7:0]        pv_r, pv_nxt;
  logic [RUN_W-1:0]  pc_r, pc_nxt;
  logic              rc_r, rc_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [RUN_W-1:0]  run_len_r, run_len_nxt;
  logic [7:0]        run_val_r, run_val_nxt;
  logic              fin_r, fin_nxt;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;

  pbrle_ram #(
    .WIDTH (8),
    .DEPTH (CHUNK_LIMIT)
  ) u_lit_ram (
    .clk   (clk),
    .we    (cmd.lit_append),
    .waddr (fill_r[ADDR_W-1:0]),
    .wdata (pv_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  // hold the address while the byte waits, so the read data holds too
  assign raddr = cmd.idx_inc ? idx_r + ADDR_W'(1) : idx_r;

  always_comb begin
    status.pc_zero     = (pc_r == '0);
    status.pc_one      = (pc_r == RUN_W'(1));
    status.pc_full     = (pc_r >= RUN_W'(CHUNK_LIMIT));
    status.byte_match  = (in_item.data_byte == pv_r);
    status.run_cont    = rc_r;
    status.fill_zero   = (fill_r == '0);
    status.fill_almost = (fill_r == FILL_W'(CHUNK_LIMIT - 1));
    status.idx_last    = ({1'b0, idx_r} + FILL_W'(1)) == fill_r;
    status.fin_in      = in_item.final_byte;
    status.fin_r       = fin_r;
  end

  always_comb begin
    case (cmd.emit_sel)
      EM_RUN_HDR:  emit_byte = 8'(RUN_BASE - 9'(run_len_r));
      EM_RUN_VAL:  emit_byte = run_val_r;
      EM_LIT_HDR:  emit_byte = 8'(fill_r - FILL_W'(1));
      EM_LIT_DATA: emit_byte = rdata;
      EM_END:      emit_byte = END_MARK;
      default:     emit_byte = END_MARK;
    endcase
  end

  always_comb begin
    pv_nxt      = pv_r;
    pc_nxt      = pc_r;
    rc_nxt      = rc_r;
    fill_nxt    = fill_r;
    idx_nxt     = idx_r;
    run_len_nxt = run_len_r;
    run_val_nxt = run_val_r;
    fin_nxt     = fin_r;
    if (cmd.accept) begin
      fin_nxt = in_item.final_byte;
    end
    if (cmd.run_load_pend) begin
      run_len_nxt = pc_r;
      run_val_nxt = pv_r;
    end else if (cmd.run_load_full) begin
      run_len_nxt = RUN_W'(CHUNK_LIMIT);
      run_val_nxt = pv_r;
    end
    if (cmd.pend_load_new) begin
      pv_nxt = in_item.data_byte;
      pc_nxt = RUN_W'(1);
      rc_nxt = 1'b0;
    end else if (cmd.pend_inc) begin
      pc_nxt = pc_r + RUN_W'(1);
    end else if (cmd.pend_cont) begin
      pc_nxt = RUN_W'(1);
      rc_nxt = 1'b1;
    end else if (cmd.pend_clear) begin
      pv_nxt = 8'd0;
      pc_nxt = '0;
      rc_nxt = 1'b0;
    end
    if (cmd.lit_append) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (cmd.fill_clear) begin
      fill_nxt = '0;
    end
    if (cmd.fill_clear) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r   <= 8'd0;
      pc_r   <= '0;
      rc_r   <= 1'b0;
      fill_r <= '0;
      idx_r  <= '0;
      fin_r  <= 1'b0;
    end else begin
      pv_r   <= pv_nxt;
      pc_r   <= pc_nxt;
      rc_r   <= rc_nxt;
      fill_r <= fill_nxt;
      idx_r  <= idx_nxt;
      fin_r  <= fin_nxt;
    end
    run_len_r <= run_len_nxt;
    run_val_r <= run_val_nxt;
  end

endmodule

`default_nettype wire

[src/pbrle_ctrl.sv]
// encoder sequencer: decides each step's actions and walks the byte emission
// depends on pbrle_pkg
`default_nettype none

module pbrle_ctrl
  import pbrle_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire status_t status,
  input  wire logic    pk_ready,
  output cmd_t         cmd
);

  state_t state_r, state_nxt;
  logic   fin_phase_r, fin_phase_nxt;
  state_t tail_in, tail_r;

  assign in_stall = (state_r != ST_IDLE);
  assign tail_in  = status.fin_in ? ST_FIN : ST_DONE;
  assign tail_r   = status.fin_r ? ST_FIN : ST_DONE;

  always_comb begin
    state_nxt     = state_r;
    fin_phase_nxt = fin_phase_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          fin_phase_nxt = 1'b0;
          if (status.pc_zero) begin
            state_nxt = tail_in;
          end else if (status.byte_match) begin
            if (status.pc_full) begin
              state_nxt = ST_RUN_HDR;
            end else if (status.pc_one && !status.run_cont && !status.fill_zero) begin
              state_nxt = ST_FLUSH_HDR;
            end else begin
              state_nxt = tail_in;
            end
          end else if (!status.pc_one || status.run_cont) begin
            state_nxt = ST_RUN_HDR;
          end else if (status.fill_almost) begin
            state_nxt = ST_FLUSH_HDR;
          end else begin
            state_nxt = tail_in;
          end
        end
      end
      ST_RUN_HDR: begin
        if (pk_ready) begin
          state_nxt = ST_RUN_VAL;
        end
      end
      ST_RUN_VAL: begin
        if (pk_ready) begin
          state_nxt = fin_phase_r ? ST_FIN_FLUSH : tail_r;
        end
      end
      ST_FLUSH_HDR: begin
        if (pk_ready) begin
          state_nxt = ST_FLUSH_DATA;
        end
      end
      ST_FLUSH_DATA: begin
        if (pk_ready && status.idx_last) begin
          state_nxt = fin_phase_r ? ST_END_MARK : tail_r;
        end
      end
      ST_FIN: begin
        fin_phase_nxt = 1'b1;
        if (!status.pc_one || status.run_cont) begin
          state_nxt = ST_RUN_HDR;
        end else if (status.fill_almost) begin
          state_nxt = ST_FLUSH_HDR;
        end else begin
          state_nxt = ST_FIN_FLUSH;
        end
      end
      ST_FIN_FLUSH: begin
        state_nxt = status.fill_zero ? ST_END_MARK : ST_FLUSH_HDR;
      end
      ST_END_MARK: begin
        if (pk_ready) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (pk_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.emit_sel = EM_RUN_HDR;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.pc_zero) begin
            cmd.pend_load_new = 1'b1;
          end else if (status.byte_match) begin
            if (status.pc_full) begin
              cmd.run_load_full = 1'b1;
              cmd.pend_cont     = 1'b1;
            end else begin
              cmd.pend_inc = 1'b1;
            end
          end else begin
            cmd.pend_load_new = 1'b1;
            if (!status.pc_one || status.run_cont) begin
              cmd.run_load_pend = 1'b1;
            end else begin
              cmd.lit_append = 1'b1;
            end
          end
        end
      end
      ST_RUN_HDR: begin
        cmd.emit_sel = EM_RUN_HDR;
        cmd.emit     = pk_ready;
      end
      ST_RUN_VAL: begin
        cmd.emit_sel = EM_RUN_VAL;
        cmd.emit     = pk_ready;
      end
      ST_FLUSH_HDR: begin
        cmd.emit_sel = EM_LIT_HDR;
        cmd.emit     = pk_ready;
      end
      ST_FLUSH_DATA: begin
        cmd.emit_sel   = EM_LIT_DATA;
        cmd.emit       = pk_ready;
        cmd.idx_inc    = pk_ready;
        cmd.fill_clear = pk_ready && status.idx_last;
      end
      ST_FIN: begin
        cmd.pend_clear = 1'b1;
        if (!status.pc_one || status.run_cont) begin
          cmd.run_load_pend = 1'b1;
        end else begin
          cmd.lit_append = 1'b1;
        end
      end
      ST_FIN_FLUSH: begin
        cmd.emit_sel = EM_LIT_HDR;
      end
      ST_END_MARK: begin
        cmd.emit_sel = EM_END;
        cmd.emit     = pk_ready;
      end
      ST_DONE: begin
        cmd.step_end = pk_ready;
      end
      default: begin
        cmd.emit_sel = EM_RUN_HDR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fin_phase_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fin_phase_r <= fin_phase_nxt;
    end
  end

endmodule

`default_nettype wire

[src/packbits_run_length_encoder.sv]
// top level of the packbits run-length encoder
// depends on pbrle_pkg, pbrle_ctrl, pbrle_datapath, pbrle_packer, pbrle_ram
//
//   channel   ports                          direction  carries
//   input     in_valid, in_stall, in_item    in         one raw byte and its final flag
//   result    out_valid, out_stall, out_item out        up to four encoded bytes per word
//
// one transaction is taken in the idle state and then sequenced; the next one is
// taken when the last word of this one sits in the output register
// each input byte takes an accept step and a done step; a run adds its header and
// value, a literal flush its header and stored bytes (one store read per cycle while
// the packer is ready), a stream's end the closing step, the literal store check and
// the end marker, with no check when the closing byte fills and flushes the store
// synchronous active-low reset returns to idle with nothing pending; the literal
// store needs no clearing since the fill count bounds every read
// a stalled result holds its word and pauses byte emission; accumulation of the
// next word continues as long as the output register can take it
`default_nettype none

module packbits_run_length_encoder
  import pbrle_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_item
);

  cmd_t       cmd;
  status_t    status;
  logic       pk_ready;
  logic [7:0] emit_byte;

  // sequencer: one byte per cycle toward the packer, gated by its ready
  pbrle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .pk_ready (pk_ready),
    .cmd      (cmd)
  );

  // open group, literal store and selection of the byte to write
  pbrle_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .emit_byte (emit_byte)
  );

  // word assembly; the last word of a transaction is held back until the step ends
  pbrle_packer u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit      (cmd.emit),
    .emit_byte (emit_byte),
    .step_end  (cmd.step_end),
    .ready     (pk_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
